/* src/wvm_pkg.sv */
// Shared types, field layout and constants of the wavetable voice mixer.
`timescale 1ns / 1ps
`default_nettype none

package wvm_pkg;

	// Input item fields and their place in s_tdata
	localparam int OP_W       = 2;
	localparam int VOICE_W    = 5;
	localparam int ADDR_W     = 10;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 11;

	localparam int OP_LSB     = 0;
	localparam int VOICE_LSB  = OP_LSB + OP_W;
	localparam int ADDR_LSB   = VOICE_LSB + VOICE_W;
	localparam int SAMPLE_LSB = ADDR_LSB + ADDR_W;
	localparam int LEN_LSB    = SAMPLE_LSB + SAMPLE_W;
	localparam int IN_BITS    = LEN_LSB + LEN_W;
	localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W  = 16;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int ACTIVE_W   = 26;
	localparam int VOL_W      = 2;
	localparam logic [VOL_W-1:0] VOLUME_RESET = 2'd3;

	// Reciprocal scaling: q = (|s| * R) >> RECIP_SHIFT, exact for 16-bit magnitudes
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 18;
	localparam int PROD_W      = SAMPLE_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_SAMPLE = 2'd0,
		OP_WRITE_LENGTH = 2'd1,
		OP_TICK         = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef enum logic {
		REG_ACTIVE_VOICES = 1'b0,
		REG_VOLUME_SEL    = 1'b1
	} reg_idx_t;

	// ceil(2^RECIP_SHIFT / d) for d = 8, 7, 6, 5
	function automatic logic [RECIP_W-1:0] volume_recip(input logic [VOL_W-1:0] level);
		logic [RECIP_W-1:0] r;
		case (level)
			2'd0:    r = 18'd131072;
			2'd1:    r = 18'd149797;
			2'd2:    r = 18'd174763;
			default: r = 18'd209716;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/wavetable_voice_mixer.sv */
// Polyphonic wavetable mixer: voice tables, sequenced voice scan and shared scaler.
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  ----------------------------------------
//  s_*       in   s_tvalid / s_tready        s_tdata: operation, voice, table_address,
//                                            sample_value, table_length
//  m_*       out  m_tvalid / m_tready        m_tdata: mixed_sample
//  apb       in   psel & penable & pwrite    0x0 active voice mask, 0x4 volume select
//
// A load request leaves s_tready high. A tick request holds s_tready low while
// one voice per cycle passes the single table read port and the multiply and
// accumulate stages drain, then the sum enters the output register.
// The output register holds a result while m_tready is low; the block keeps taking
// load requests meanwhile, and a following tick stalls only at its final hand-off.
// Reset sets every voice length to 1 and position to 0, clears the voice mask and
// sets the volume select to 3; the table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_voice_mixer #(
	parameter int VOICE_COUNT = 26,
	parameter int TABLE_DEPTH = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [wvm_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire [wvm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [wvm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// requests: operation, voice, table_address, sample_value, table_length (low bit up)
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [wvm_pkg::S_TDATA_W-1:0]     s_tdata,
	// results: mixed_sample
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [wvm_pkg::M_TDATA_W-1:0]    m_tdata
);
	import wvm_pkg::*;

	localparam int VW        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int PW        = $clog2(TABLE_DEPTH);
	localparam int LW        = $clog2(TABLE_DEPTH + 1);
	localparam int MEM_DEPTH = VOICE_COUNT * TABLE_DEPTH;
	localparam int MAW       = $clog2(MEM_DEPTH);
	localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

	// configuration registers
	logic [ACTIVE_W-1:0] active_q;
	logic [VOL_W-1:0]    volume_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	// request fields
	op_t                 req_op;
	logic [VOICE_W-1:0]  req_voice;
	logic [ADDR_W-1:0]   req_addr;
	logic [SAMPLE_W-1:0] req_sample;
	logic [LEN_W-1:0]    req_len;
	logic                accept;
	logic                voice_ok;
	logic [LW-1:0]       len_clamped;

	// sequencer
	state_t              state_q;
	state_t              state_nxt;
	logic [VW-1:0]       cnt_q;
	logic                tick_start;
	logic                issue;
	logic                drained;
	logic                out_load;

	// per-voice state
	logic [LW-1:0]          len_q [VOICE_COUNT];
	logic [PW-1:0]          pos_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] voice_on;
	logic [PW-1:0]          pos_cur;
	logic [LW-1:0]          pos_inc;
	logic [PW-1:0]          pos_nxt;
	logic                   rd_en;

	// table memory
	logic [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
	logic                mem_wr;
	logic [MAW-1:0]      wr_addr;
	logic [MAW-1:0]      rd_addr;

	// scaling pipeline
	logic                vld_s1;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic [SAMPLE_W-1:0] mag;
	logic                vld_s2;
	logic                neg_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [QUOT_W-1:0]   quot;
	logic [SAMPLE_W-1:0] term;
	logic [SAMPLE_W-1:0] acc_q;

	// output register
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			volume_q <= VOLUME_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ACTIVE_VOICES: active_q <= pwdata[ACTIVE_W-1:0];
				REG_VOLUME_SEL:    volume_q <= pwdata[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ACTIVE_VOICES: prdata = APB_DATA_W'(active_q);
			REG_VOLUME_SEL:    prdata = APB_DATA_W'(volume_q);
			default:           prdata = '0;
		endcase
	end

	// Mask bits beyond the implemented voices have no effect; voices beyond the
	// register width never sound.
	for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice_on
		if (v < ACTIVE_W) begin : g_mapped
			assign voice_on[v] = active_q[v];
		end else begin : g_unmapped
			assign voice_on[v] = 1'b0;
		end
	end

	// ---------------------------------------------------------------- request decode
	assign req_op     = op_t'(s_tdata[OP_LSB +: OP_W]);
	assign req_voice  = s_tdata[VOICE_LSB +: VOICE_W];
	assign req_addr   = s_tdata[ADDR_LSB +: ADDR_W];
	assign req_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];
	assign req_len    = s_tdata[LEN_LSB +: LEN_W];
	assign accept     = s_tvalid & s_tready;
	assign voice_ok   = 32'(req_voice) < VOICE_COUNT;

	// Zero length becomes one, anything past the table depth is clipped to it.
	always_comb begin
		if (req_len == '0) begin
			len_clamped = LW'(1);
		end else if (32'(req_len) > TABLE_DEPTH) begin
			len_clamped = LW'(TABLE_DEPTH);
		end else begin
			len_clamped = LW'(req_len);
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (tick_start) begin
				cnt_q <= '0;
			end else if (issue && cnt_q != LAST_VOICE) begin
				cnt_q <= cnt_q + VW'(1);
			end
		end
	end

	// The pipeline is empty and the output register free: hand the sum over.
	assign drained = !vld_s1 && !vld_s2 && (!m_tvalid_q || m_tready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (tick_start) begin
				state_nxt = ST_SCAN;
			end
			ST_SCAN:  if (cnt_q == LAST_VOICE) begin
				state_nxt = ST_DRAIN;
			end
			ST_DRAIN: if (drained) begin
				state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		issue      = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_SCAN:  issue    = 1'b1;
			ST_DRAIN: out_load = drained;
			default:  ;
		endcase
	end

	assign tick_start = accept && req_op == OP_TICK;

	// ---------------------------------------------------------------- voice state
	assign pos_cur = pos_q[cnt_q];
	assign pos_inc = LW'(pos_cur) + LW'(1);
	assign pos_nxt = (pos_inc >= len_q[cnt_q]) ? '0 : PW'(pos_inc);
	assign rd_en   = issue && voice_on[cnt_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				len_q[v] <= LW'(1);
				pos_q[v] <= '0;
			end
		end else if (accept && req_op == OP_WRITE_LENGTH && voice_ok) begin
			// a new length restarts the voice at the head of its table
			len_q[VW'(req_voice)] <= len_clamped;
			pos_q[VW'(req_voice)] <= '0;
		end else if (rd_en) begin
			pos_q[cnt_q] <= pos_nxt;
		end
	end

	// ---------------------------------------------------------------- table memory
	assign mem_wr  = accept && req_op == OP_WRITE_SAMPLE && voice_ok
	                 && 32'(req_addr) < TABLE_DEPTH;
	assign wr_addr = MAW'(32'(req_voice) * 32'(TABLE_DEPTH) + 32'(req_addr));
	assign rd_addr = MAW'(32'(cnt_q) * 32'(TABLE_DEPTH) + 32'(pos_cur));

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			wave_mem[wr_addr] <= req_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= wave_mem[rd_addr];
		end
	end

	// ---------------------------------------------------------------- scale and sum
	// Divide the magnitude by the volume divisor through its reciprocal, then
	// restore the sign: truncation toward zero.
	assign mag  = rdata_s1[SAMPLE_W-1] ? (SAMPLE_W'(0) - rdata_s1) : rdata_s1;
	assign quot = prod_s2[RECIP_SHIFT +: QUOT_W];
	assign term = neg_s2 ? (SAMPLE_W'(0) - SAMPLE_W'(quot)) : SAMPLE_W'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(volume_recip(volume_q));
			neg_s2  <= rdata_s1[SAMPLE_W-1];
		end
		if (tick_start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + term;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= acc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* src/wvm_checker.sv */
// Port-level checks of the wavetable voice mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wvm_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire [wvm_pkg::S_TDATA_W-1:0]     s_tdata,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [wvm_pkg::M_TDATA_W-1:0]     m_tdata
);
	import wvm_pkg::*;

	logic tick_req;
	logic load_req;

	assign tick_req = s_tvalid && s_tready && s_tdata[OP_LSB +: OP_W] == OP_TICK;
	assign load_req = s_tvalid && s_tready && (s_tdata[OP_LSB +: OP_W] == OP_WRITE_SAMPLE
	                  || s_tdata[OP_LSB +: OP_W] == OP_WRITE_LENGTH);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// drop ready while a tick scans the voices
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_req |=> !s_tready)
		else $error("request taken during voice scan");

	// advance straight to the next request after a load
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		load_req |=> s_tready)
		else $error("load request did not finish in one cycle");

	// never produce a tick result in the cycle right after its request
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_req && !m_tvalid |=> !m_tvalid)
		else $error("result appeared before the voice scan");

	// a new result arrives together with the return to idle
	a_result_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result issued while still busy");

endmodule

bind wavetable_voice_mixer wvm_checker u_wvm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
